// ----- sv/waypoint_guidance_step_top_defines.svh -----
// Assertion macros shared by the waypoint guidance step RTL.
// Included by waypoint_guidance_step_top; depends on nothing else.
`ifndef WAYPOINT_GUIDANCE_STEP_TOP_DEFINES_SVH
`define WAYPOINT_GUIDANCE_STEP_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WGS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WGS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/wgs_pkg.sv -----
// Types, stage plan and per-stage arithmetic of the waypoint guidance step.
// Used by waypoint_guidance_step_top; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package wgs_pkg;

  localparam int IN_W  = 352;
  localparam int OUT_W = 336;

  localparam int ROOT_STEPS = 34;
  localparam int DIV_STEPS  = 33;

  localparam int ST_LOAD = 0;
  localparam int SQ_A    = ST_LOAD + 1;
  localparam int SUM_A   = SQ_A + 1;
  localparam int RT_A    = SUM_A + 1;
  localparam int TV1     = RT_A + ROOT_STEPS;
  localparam int TV2     = TV1 + 1;
  localparam int DV_B    = TV2 + 1;
  localparam int TVD     = DV_B + DIV_STEPS;
  localparam int SQ_C    = TVD + 1;
  localparam int SUM_C   = SQ_C + 1;
  localparam int RT_C    = SUM_C + 1;
  localparam int SC1     = RT_C + ROOT_STEPS;
  localparam int SC2     = SC1 + 1;
  localparam int DV_D    = SC2 + 1;
  localparam int NVS     = DV_D + DIV_STEPS;
  localparam int SQ_E    = NVS + 1;
  localparam int SUM_E   = SQ_E + 1;
  localparam int RT_E    = SUM_E + 1;
  localparam int DR1     = RT_E + ROOT_STEPS;
  localparam int DR2     = DR1 + 1;
  localparam int W1      = DR2 + 1;
  localparam int W2      = W1 + 1;
  localparam int G1      = W2 + 1;
  localparam int G2      = G1 + 1;
  localparam int DV_G    = G2 + 1;
  localparam int FIN     = DV_G + DIV_STEPS;
  localparam int NSTAGE  = FIN + 1;

  localparam logic [33:0] NEAR_DIST = 34'd6554;
  localparam logic [33:0] DISP_CAP  = 34'h2_0000_0000;
  localparam logic signed [63:0] SAT_HI = 64'sh7FFF_FFFF;
  localparam logic signed [63:0] SAT_LO = -64'sh8000_0000;
  localparam logic signed [31:0] ACC_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ACC_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    REG_SPEED = 2'd0,
    REG_ACCEL = 2'd1,
    REG_CLIMB = 2'd2,
    REG_DRAG  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [30:0] speed;
    logic [30:0] accel;
    logic [30:0] climb;
    logic [15:0] drag;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{speed: 31'd655360, accel: 31'd327680,
                                 climb: 31'd196608, drag: 16'd6554};

  typedef struct packed {
    logic [2:0][31:0] p;
    logic [2:0][31:0] v;
    logic [15:0]      dt;
    logic [47:0]      tn;
    logic [2:0][34:0] vec;
    logic [2:0][67:0] sq;
    logic [67:0]      rad;
    logic [35:0]      rem;
    logic [33:0]      root;
    logic [2:0][32:0] mag;
    logic [2:0]       sgn;
    logic             flag;
    logic [33:0]      mul_s;
    logic [33:0]      den;
    logic [2:0][67:0] pr;
    logic [34:0]      maxc;
    logic [49:0]      fm;
    logic [37:0]      f;
    logic [2:0][51:0] pp_lo;
    logic [2:0][51:0] pp_hi;
    logic [2:0][59:0] w;
    logic [2:0][60:0] emag;
    logic [2:0][60:0] xmag;
    logic [2:0]       xsgn;
    logic [2:0]       ovf;
    logic [2:0][33:0] disp;
    logic [8:0][31:0] res;
  } item_t;

  function automatic logic [31:0] sat32(logic signed [63:0] x);
    if (x > SAT_HI) return 32'h7FFF_FFFF;
    else if (x < SAT_LO) return 32'h8000_0000;
    else return x[31:0];
  endfunction

  function automatic logic [32:0] mag35(logic [34:0] x);
    logic [34:0] m;
    m = x[34] ? 35'(-$signed(x)) : x;
    return m[32:0];
  endfunction

  function automatic item_t ph_load(logic [IN_W-1:0] d);
    item_t r;
    logic signed [34:0] pp, gg;
    logic [48:0] ts;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      r.p[i] = d[32*i +: 32];
      r.v[i] = d[96 + 32*i +: 32];
      pp = $signed(d[32*i +: 32]);
      gg = $signed(d[192 + 32*i +: 32]);
      r.vec[i] = gg - pp;
    end
    r.dt = d[303:288];
    ts = {1'b0, d[351:304]} + {29'd0, d[303:288], 4'd0};
    r.tn = ts[48] ? '1 : ts[47:0];
    return r;
  endfunction

  function automatic item_t ph_square(item_t a, cfg_t c);
    item_t r;
    logic [34:0] m;
    logic [46:0] mx;
    r = a;
    for (int i = 0; i < 3; i++) begin
      m = a.vec[i][34] ? 35'(-$signed(a.vec[i])) : a.vec[i];
      r.sq[i] = m[33:0] * m[33:0];
    end
    mx = c.accel * a.dt;
    r.maxc = mx[46:12];
    return r;
  endfunction

  function automatic item_t ph_sum(item_t a);
    item_t r;
    r = a;
    r.rad = a.sq[0] + a.sq[1] + a.sq[2];
    r.rem = '0;
    r.root = '0;
    return r;
  endfunction

  function automatic item_t root_step(item_t a);
    item_t r;
    logic [37:0] rem2, trial;
    r = a;
    rem2 = {a.rem, a.rad[67:66]};
    trial = {2'b00, a.root, 2'b01};
    if (rem2 >= trial) begin
      r.rem = 36'(rem2 - trial);
      r.root = {a.root[32:0], 1'b1};
    end else begin
      r.rem = rem2[35:0];
      r.root = {a.root[32:0], 1'b0};
    end
    r.rad = {a.rad[65:0], 2'b00};
    return r;
  endfunction

  function automatic item_t div_step(item_t a);
    item_t r;
    logic [67:0] t;
    logic [34:0] hi;
    r = a;
    for (int i = 0; i < 3; i++) begin
      t = {a.pr[i][66:0], 1'b0};
      hi = t[67:33];
      if (hi >= {1'b0, a.den}) begin
        t[67:33] = hi - {1'b0, a.den};
        t[0] = 1'b1;
      end
      r.pr[i] = t;
    end
    return r;
  endfunction

  function automatic item_t ph_tv1(item_t a, cfg_t c);
    item_t r;
    logic [33:0] half;
    r = a;
    r.flag = (a.root >= NEAR_DIST);
    half = {1'b0, a.root[33:1]};
    r.mul_s = (half > {3'b0, c.speed}) ? {3'b0, c.speed} : half;
    r.den = r.flag ? a.root : 34'd1;
    for (int i = 0; i < 3; i++) begin
      r.mag[i] = mag35(a.vec[i]);
      r.sgn[i] = a.vec[i][34];
    end
    return r;
  endfunction

  function automatic item_t ph_sc1(item_t a);
    item_t r;
    r = a;
    r.flag = ({1'b0, a.root} > a.maxc);
    r.mul_s = a.maxc[33:0];
    r.den = r.flag ? a.root : 34'd1;
    for (int i = 0; i < 3; i++) begin
      r.mag[i] = mag35(a.vec[i]);
      r.sgn[i] = a.vec[i][34];
    end
    return r;
  endfunction

  function automatic item_t ph_mul(item_t a);
    item_t r;
    logic [66:0] pm;
    r = a;
    for (int i = 0; i < 3; i++) begin
      pm = a.mag[i] * a.mul_s;
      r.pr[i] = a.flag ? {1'b0, pm} : '0;
    end
    return r;
  endfunction

  function automatic item_t ph_tvd(item_t a, cfg_t c);
    item_t r;
    logic signed [34:0] tv, cl, vv;
    logic [34:0] q;
    r = a;
    cl = $signed({4'b0, c.climb});
    for (int i = 0; i < 3; i++) begin
      q = {2'b0, a.pr[i][32:0]};
      tv = a.sgn[i] ? -$signed(q) : $signed(q);
      if (i == 2) begin
        if (tv > cl) tv = cl;
        else if (tv < -cl) tv = -cl;
      end
      vv = $signed(a.v[i]);
      r.vec[i] = tv - vv;
    end
    return r;
  endfunction

  function automatic item_t ph_nv(item_t a);
    item_t r;
    logic signed [34:0] cc, qs, vv;
    r = a;
    for (int i = 0; i < 3; i++) begin
      qs = $signed({2'b0, a.pr[i][32:0]});
      if (a.sgn[i]) qs = -qs;
      cc = a.flag ? qs : $signed(a.vec[i]);
      vv = $signed(a.v[i]);
      r.vec[i] = vv + cc;
    end
    return r;
  endfunction

  function automatic item_t ph_dr1(item_t a, cfg_t c);
    item_t r;
    r = a;
    r.fm = c.drag * a.root;
    for (int i = 0; i < 3; i++) begin
      r.mag[i] = mag35(a.vec[i]);
      r.sgn[i] = a.vec[i][34];
    end
    return r;
  endfunction

  function automatic item_t ph_dr2(item_t a);
    item_t r;
    logic [65:0] pf;
    r = a;
    pf = a.fm * a.dt;
    r.f = pf[65:28];
    return r;
  endfunction

  function automatic item_t ph_w1(item_t a);
    item_t r;
    r = a;
    for (int i = 0; i < 3; i++) begin
      r.pp_lo[i] = a.mag[i] * a.f[18:0];
      r.pp_hi[i] = a.mag[i] * a.f[37:19];
    end
    return r;
  endfunction

  function automatic item_t ph_w2(item_t a);
    item_t r;
    logic [70:0] qq;
    logic signed [59:0] qs, nv;
    r = a;
    for (int i = 0; i < 3; i++) begin
      qq = {19'b0, a.pp_lo[i]} + {a.pp_hi[i], 19'b0};
      qs = $signed({5'b0, qq[70:16]});
      if (a.sgn[i]) qs = -qs;
      nv = $signed(a.vec[i]);
      r.w[i] = nv - qs;
    end
    return r;
  endfunction

  function automatic item_t ph_g1(item_t a);
    item_t r;
    logic signed [61:0] ww, vv, e, x;
    r = a;
    for (int i = 0; i < 3; i++) begin
      ww = $signed(a.w[i]);
      vv = $signed(a.v[i]);
      e = ww - vv;
      x = (ww <<< 1) + ww - vv;
      r.sgn[i] = e[61];
      r.emag[i] = e[61] ? 61'(-e) : e[60:0];
      r.xsgn[i] = x[61];
      r.xmag[i] = x[61] ? 61'(-x) : x[60:0];
    end
    return r;
  endfunction

  function automatic item_t ph_g2(item_t a);
    item_t r;
    logic [61:0] pd;
    logic [48:0] dq;
    logic dz;
    r = a;
    dz = (a.dt == '0);
    r.den = dz ? 34'd1 : {18'b0, a.dt};
    for (int i = 0; i < 3; i++) begin
      r.ovf[i] = (a.emag[i][60:19] >= {26'b0, a.dt});
      r.pr[i] = (dz || r.ovf[i]) ? '0 : {a.emag[i][55:0], 12'b0};
      pd = a.xmag[i][45:0] * a.dt;
      dq = pd[61:13];
      if (dz) r.disp[i] = '0;
      else if (|a.xmag[i][60:46]) r.disp[i] = DISP_CAP;
      else if (dq > {15'b0, DISP_CAP}) r.disp[i] = DISP_CAP;
      else r.disp[i] = dq[33:0];
    end
    return r;
  endfunction

  function automatic item_t ph_fin(item_t a);
    item_t r;
    logic signed [35:0] ps, dsp;
    logic signed [31:0] acc, qs;
    r = a;
    for (int i = 0; i < 3; i++) begin
      dsp = $signed({2'b0, a.disp[i]});
      if (a.xsgn[i]) dsp = -dsp;
      ps = $signed(a.p[i]) + dsp;
      r.res[i] = sat32(ps);
      r.res[3 + i] = sat32($signed(a.w[i]));
      qs = $signed({1'b0, a.pr[i][30:0]});
      if (a.dt == '0) acc = '0;
      else if (a.ovf[i]) acc = a.sgn[i] ? ACC_MIN : ACC_MAX;
      else acc = a.sgn[i] ? -qs : qs;
      r.res[6 + i] = acc;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/waypoint_guidance_step_top.sv -----
// Top level of the waypoint guidance step: one fully pipelined update path.
// Depends on wgs_pkg and waypoint_guidance_step_top_defines.svh.
//
//  Channel  Dir  Handshake            Payload
//  in_      in   in_tvalid/in_tready  vehicle state, goal, step, time
//  out_     out  out_tvalid/out_tready next state, acceleration, time
//  cfg_     in   cfg_valid/cfg_ready  register index and write data
//
// One request is taken per cycle while the output is not stalled.
// The pipeline holds three 34-step square roots and three 33-step dividers.
// Reset is synchronous and active low; it clears the valid bits and loads the
// configuration registers with their reset values.
// A result held at the output stalls the whole pipeline, so nothing is lost.
`timescale 1ns / 1ps
`default_nettype none
`include "waypoint_guidance_step_top_defines.svh"

module waypoint_guidance_step_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, goal_x, goal_y, goal_z,
  // time_step, cur_time
  input  logic [wgs_pkg::IN_W-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // next_pos_x, next_pos_y, next_pos_z, next_vel_x, next_vel_y, next_vel_z,
  // accel_x, accel_y, accel_z, next_time
  output logic [wgs_pkg::OUT_W-1:0] out_tdata,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [31:0]               cfg_data
);
  import wgs_pkg::*;

  cfg_t              cfg_r, cfg_nxt;
  item_t             st_r   [NSTAGE];
  item_t             st_nxt [NSTAGE];
  logic [NSTAGE-1:0] vld_r, vld_nxt;
  logic              en;

  assign en        = !vld_r[NSTAGE-1] || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SPEED: cfg_nxt.speed = cfg_data[30:0];
        REG_ACCEL: cfg_nxt.accel = cfg_data[30:0];
        REG_CLIMB: cfg_nxt.climb = cfg_data[30:0];
        REG_DRAG:  cfg_nxt.drag  = cfg_data[15:0];
      endcase
    end
  end

  assign vld_nxt = en ? {vld_r[NSTAGE-2:0], in_tvalid} : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      cfg_r <= CFG_RESET;
    end else begin
      vld_r <= vld_nxt;
      cfg_r <= cfg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NSTAGE; k++) st_r[k] <= st_nxt[k];
    end
  end

  assign st_nxt[ST_LOAD] = ph_load(in_tdata);

  for (genvar k = 1; k < NSTAGE; k++) begin : g_stage
    if (k == SQ_A || k == SQ_C || k == SQ_E) begin : g_sq
      assign st_nxt[k] = ph_square(st_r[k-1], cfg_r);
    end else if (k == SUM_A || k == SUM_C || k == SUM_E) begin : g_sum
      assign st_nxt[k] = ph_sum(st_r[k-1]);
    end else if ((k >= RT_A && k < RT_A + ROOT_STEPS) ||
                 (k >= RT_C && k < RT_C + ROOT_STEPS) ||
                 (k >= RT_E && k < RT_E + ROOT_STEPS)) begin : g_root
      assign st_nxt[k] = root_step(st_r[k-1]);
    end else if ((k >= DV_B && k < DV_B + DIV_STEPS) ||
                 (k >= DV_D && k < DV_D + DIV_STEPS) ||
                 (k >= DV_G && k < DV_G + DIV_STEPS)) begin : g_div
      assign st_nxt[k] = div_step(st_r[k-1]);
    end else if (k == TV1) begin : g_tv1
      assign st_nxt[k] = ph_tv1(st_r[k-1], cfg_r);
    end else if (k == TV2 || k == SC2) begin : g_mul
      assign st_nxt[k] = ph_mul(st_r[k-1]);
    end else if (k == TVD) begin : g_tvd
      assign st_nxt[k] = ph_tvd(st_r[k-1], cfg_r);
    end else if (k == SC1) begin : g_sc1
      assign st_nxt[k] = ph_sc1(st_r[k-1]);
    end else if (k == NVS) begin : g_nv
      assign st_nxt[k] = ph_nv(st_r[k-1]);
    end else if (k == DR1) begin : g_dr1
      assign st_nxt[k] = ph_dr1(st_r[k-1], cfg_r);
    end else if (k == DR2) begin : g_dr2
      assign st_nxt[k] = ph_dr2(st_r[k-1]);
    end else if (k == W1) begin : g_w1
      assign st_nxt[k] = ph_w1(st_r[k-1]);
    end else if (k == W2) begin : g_w2
      assign st_nxt[k] = ph_w2(st_r[k-1]);
    end else if (k == G1) begin : g_g1
      assign st_nxt[k] = ph_g1(st_r[k-1]);
    end else if (k == G2) begin : g_g2
      assign st_nxt[k] = ph_g2(st_r[k-1]);
    end else begin : g_fin
      assign st_nxt[k] = ph_fin(st_r[k-1]);
    end
  end

  assign out_tvalid = vld_r[NSTAGE-1];
  assign out_tdata  = {st_r[NSTAGE-1].tn, st_r[NSTAGE-1].res};

  `WGS_ASSERT_NEXT(a_accept_enters, clk, rst_n, in_tvalid && in_tready, vld_r[0], "accepted request missing from first stage")
  `WGS_ASSERT_NEXT(a_stall_holds, clk, rst_n, !en, $stable(vld_r), "valid bits moved during a stall")
  `WGS_ASSERT_NEXT(a_reach_output, clk, rst_n, en && vld_r[NSTAGE-2], out_tvalid, "request lost before the output stage")
  `WGS_ASSERT_NEXT(a_drag_write, clk, rst_n, cfg_valid && cfg_ready && (cfg_index == REG_DRAG), cfg_r.drag == $past(cfg_data[15:0]), "drag register write not taken")

endmodule

`default_nettype wire
